/* hw/rtl/htwd_pkg.sv */
// ----------------------------------------------------------------------------
// htwd_pkg: shared types and constants of the code tree walk decoder
// Node entry layout, result layout, operation and status codes, state type.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int DEF_NODE_COUNT = 512;
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 8;
    localparam int M_TUSER_W      = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Input item kinds carried on s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_HEADER = 2'd1;
    localparam logic [1:0] STAT_UNLOADED   = 2'd2;

    // Register index, taken from paddr[2].
    localparam logic REG_ROOT_NODE = 1'b0;

    typedef struct packed {
        logic             loaded;
        logic             leaf;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] symbol;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             has_symbol;
        logic [1:0]       status;
    } result_t;

    typedef enum logic [2:0] {
        W_CLEAR,
        W_IDLE,
        W_STEP,
        W_LAND,
        W_FAIL,
        W_END,
        W_FINISH
    } walk_state_t;

endpackage

/* hw/rtl/htwd_node_mem.sv */
// ----------------------------------------------------------------------------
// htwd_node_mem: node store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module htwd_node_mem import htwd_pkg::*; #(
    parameter int DEPTH = DEF_NODE_COUNT,
    parameter int WIDTH = NODE_W
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] node_mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/htwd_apb_regs.sv */
// ----------------------------------------------------------------------------
// htwd_apb_regs: configuration register bank
// Holds the root node index, written and read over the APB port.
// ----------------------------------------------------------------------------
module htwd_apb_regs import htwd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [IDX_W-1:0]      root_node
);

    logic [IDX_W-1:0] root_reg;
    logic [IDX_W-1:0] root_next;
    logic             reg_sel;

    assign reg_sel = (paddr[2] == REG_ROOT_NODE);
    assign pready  = 1'b1;

    always_comb begin
        root_next = root_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            root_next = pwdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else begin
            root_reg <= root_next;
        end
    end

    assign prdata    = reg_sel ? {{(APB_DATA_W-IDX_W){1'b0}}, root_reg} : '0;
    assign root_node = root_reg;

endmodule

/* hw/rtl/htwd_walker.sv */
// ----------------------------------------------------------------------------
// htwd_walker: bit-serial tree walk sequencer
// Shifts each byte out one bit at a time, steps through the node store and
// queues results through a one-deep pending slot and an output register.
// ----------------------------------------------------------------------------
module htwd_walker import htwd_pkg::*; #(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [IDX_W-1:0]              root_node,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,
    output logic [M_TUSER_W-1:0]          m_tuser,
    output logic                          m_tlast,
    output logic                          mem_we,
    output logic [$clog2(NODE_COUNT)-1:0] mem_waddr,
    output node_t                         mem_wdata,
    output logic [$clog2(NODE_COUNT)-1:0] mem_raddr,
    input  node_t                         mem_rdata
);

    localparam int AW = $clog2(NODE_COUNT);

    walk_state_t      state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             await_reg, await_next;
    logic [3:0]       fvb_reg, fvb_next;
    logic             err_reg, err_next;
    logic [SYM_W-1:0] shift_reg, shift_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             fin_reg, fin_next;
    logic             fail_reg, fail_next;
    logic             ok_reg, ok_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;
    logic             out_eof_reg, out_eof_next;
    logic             out_last_reg, out_last_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;

    logic [IDX_W-1:0] in_index;
    logic [IDX_W-1:0] in_left;
    logic [IDX_W-1:0] in_right;
    logic [SYM_W-1:0] in_symbol;
    logic [SYM_W-1:0] in_byte;
    logic             in_acc;
    logic             out_free;
    logic             cur_bad;
    logic             land_stall;
    logic             header_good;
    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] rd_idx;

    // Input item fields, lowest bits first.
    assign in_index  = s_tdata[8:0];
    assign in_left   = s_tdata[18:10];
    assign in_right  = s_tdata[27:19];
    assign in_symbol = s_tdata[35:28];
    assign in_byte   = s_tdata[43:36];

    assign in_acc      = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign cur_bad     = !(ok_reg && mem_rdata.loaded);
    assign child       = shift_reg[0] ? mem_rdata.right : mem_rdata.left;
    assign header_good = (in_byte != '0) && (in_byte <= SYM_W'(BYTE_BITS));
    // A leaf reached while the pending slot cannot drain waits with the
    // read address held, so the node entry stays on the read port.
    assign land_stall  = (state_reg == W_LAND) && !cur_bad && mem_rdata.leaf
                         && pend_valid_reg && !out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            W_CLEAR: begin
                if (32'(clr_cnt_reg) == NODE_COUNT - 1) begin
                    state_next = W_IDLE;
                end
            end
            W_IDLE: begin
                if (in_acc && (s_tuser == OP_BYTE)) begin
                    if (err_reg) begin
                        state_next = s_tlast ? W_FINISH : W_IDLE;
                    end else if (await_reg) begin
                        state_next = (header_good && !s_tlast) ? W_IDLE : W_FINISH;
                    end else begin
                        state_next = W_STEP;
                    end
                end
            end
            W_STEP: begin
                state_next = cur_bad ? W_FAIL : W_LAND;
            end
            W_LAND: begin
                if (cur_bad) begin
                    state_next = W_FAIL;
                end else if (!land_stall) begin
                    state_next = (cnt_reg == '0) ? W_END : W_STEP;
                end
            end
            W_FAIL: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = W_FINISH;
                end
            end
            W_END: begin
                state_next = (pend_valid_reg || fin_reg) ? W_FINISH : W_IDLE;
            end
            W_FINISH: begin
                if (out_free) begin
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Handshake and node store control.
    always_comb begin
        s_tready  = (state_reg == W_IDLE);
        mem_we    = 1'b0;
        mem_waddr = AW'(in_index);
        mem_wdata = '{loaded: 1'b1, leaf: s_tdata[9], left: in_left,
                      right: in_right, symbol: in_symbol};
        rd_idx    = pos_reg;
        case (state_reg)
            W_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            W_IDLE: begin
                mem_we = in_acc && (s_tuser == OP_LOAD) && (32'(in_index) < NODE_COUNT);
            end
            W_STEP: begin
                rd_idx = child;
            end
            W_LAND: begin
                if (!cur_bad && mem_rdata.leaf && !land_stall) begin
                    rd_idx = root_node;
                end
            end
            default: begin
                rd_idx = pos_reg;
            end
        endcase
        mem_raddr = AW'(rd_idx);
    end

    // Datapath next values.
    always_comb begin
        pos_next        = pos_reg;
        await_next      = await_reg;
        fvb_next        = fvb_reg;
        err_next        = err_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        fin_next        = fin_reg;
        fail_next       = fail_reg;
        ok_next         = 32'(rd_idx) < NODE_COUNT;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_res_next    = out_res_reg;
        out_eof_next    = out_eof_reg;
        out_last_next   = out_last_reg;
        clr_cnt_next    = clr_cnt_reg;
        case (state_reg)
            W_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            W_IDLE: begin
                if (in_acc && (s_tuser == OP_BYTE)) begin
                    fin_next   = s_tlast;
                    fail_next  = 1'b0;
                    shift_next = in_byte;
                    cnt_next   = s_tlast ? fvb_reg : BYTE_BITS;
                    if (err_reg) begin
                        pend_valid_next = s_tlast;
                        pend_next       = '{symbol: '0, has_symbol: 1'b0, status: STAT_OK};
                    end else if (await_reg) begin
                        if (header_good) begin
                            fvb_next        = in_byte[3:0];
                            await_next      = 1'b0;
                            pos_next        = root_node;
                            pend_valid_next = s_tlast;
                            pend_next       = '{symbol: '0, has_symbol: 1'b0,
                                                status: STAT_OK};
                        end else begin
                            fail_next       = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_next       = '{symbol: '0, has_symbol: 1'b0,
                                                status: STAT_BAD_HEADER};
                        end
                    end
                end
            end
            W_STEP: begin
                if (!cur_bad) begin
                    pos_next   = child;
                    shift_next = shift_reg >> 1;
                    cnt_next   = cnt_reg - 1'b1;
                end
            end
            W_LAND: begin
                if (!cur_bad && mem_rdata.leaf && !land_stall) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_res_next   = pend_reg;
                        out_eof_next   = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = '{symbol: mem_rdata.symbol, has_symbol: 1'b1,
                                        status: STAT_OK};
                    pos_next        = root_node;
                end
            end
            W_FAIL: begin
                fail_next = 1'b1;
                if (pend_valid_reg && out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = pend_reg;
                    out_eof_next   = 1'b0;
                    out_last_next  = 1'b0;
                end
                if (!pend_valid_reg || out_free) begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{symbol: '0, has_symbol: 1'b0, status: STAT_UNLOADED};
                end
            end
            W_END: begin
                if (!pend_valid_reg && fin_reg) begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{symbol: '0, has_symbol: 1'b0, status: STAT_OK};
                end
            end
            W_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_reg;
                    out_eof_next    = fin_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    if (fin_reg) begin
                        await_next = 1'b1;
                        err_next   = 1'b0;
                        pos_next   = root_node;
                    end else if (fail_reg) begin
                        err_next = 1'b1;
                    end
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= W_CLEAR;
            pos_reg        <= '0;
            await_reg      <= 1'b1;
            fvb_reg        <= BYTE_BITS;
            err_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            fail_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            await_reg      <= await_next;
            fvb_reg        <= fvb_next;
            err_reg        <= err_next;
            fin_reg        <= fin_next;
            fail_reg       <= fail_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        ok_reg       <= ok_next;
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_eof_reg  <= out_eof_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.symbol;
    assign m_tuser  = {out_res_reg.status, out_eof_reg, out_res_reg.has_symbol};
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == W_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over while idle");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == W_STEP) || (state_reg == W_LAND)) |-> (cnt_reg <= BYTE_BITS))
        else $error("bit count out of range");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_eof_reg |-> out_last_reg)
        else $error("end of file on a result that is not last of its run");

    a_status_no_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_res_reg.status != STAT_OK) |-> !out_res_reg.has_symbol)
        else $error("error result carries a symbol");
`endif

endmodule

/* hw/rtl/huffman_tree_walk_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top: code tree walk decoder
// Loads a code tree into a node store and decodes compressed bytes into symbols.
// ----------------------------------------------------------------------------
// Usage
//   The s_ stream carries node loads (s_tuser = 0) and compressed file bytes
//   (s_tuser = 1, s_tlast on the final byte of a file). The m_ stream returns
//   decoded symbols and status events; m_tlast closes the results of one
//   input transaction. The user must write the APB root node register only while
//   idle; the block itself does not enforce this. A data byte is walked bit by
//   bit, each step waiting for one node store read. A decoded symbol waits in
//   a pending slot until the next result is decided. After reset the node
//   store is swept once to mark every node as not loaded, with s_tready low.
//   When the receiver stalls, the output register and the pending slot fill
//   up and the walk waits at the next leaf.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top import htwd_pkg::*; #(
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: node_index[8:0], node_is_leaf[9], left_child[18:10],
    //          right_child[27:19], leaf_symbol[35:28], data_byte[43:36], zero
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // op
    input  logic                  s_tlast,   // final_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // symbol[7:0]
    output logic [M_TUSER_W-1:0]  m_tuser,   // has_symbol[0], end_of_file[1], status[3:2]
    output logic                  m_tlast,   // last_of_run
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [IDX_W-1:0] root_node;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    node_t            mem_wdata;
    logic [AW-1:0]    mem_raddr;
    node_t            mem_rdata;

    htwd_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .root_node (root_node)
    );

    htwd_node_mem #(
        .DEPTH (NODE_COUNT),
        .WIDTH (NODE_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    htwd_walker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .root_node (root_node),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the code tree walk decoder
// Loads random code trees, feeds compressed files and checks every decoded
// symbol and status event against a predictor that tracks the node store and
// the walk state. Both streams idle at random, and once the result side holds
// off long enough for the decoder to stall its input.
// ----------------------------------------------------------------------------
module tb_top import htwd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_MAX     = DEF_NODE_COUNT - 1;
    // Node indices in this window are never loaded, so steps into them fail.
    localparam int HOLE_LO      = 300;
    localparam int HOLE_HI      = 307;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 230;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             has_symbol;
        logic             end_of_file;
        logic [1:0]       status;
        logic             last_of_run;
    } walk_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted decoder state.
    bit               tree_loaded [DEF_NODE_COUNT];
    logic             tree_leaf   [DEF_NODE_COUNT];
    logic [IDX_W-1:0] tree_left   [DEF_NODE_COUNT];
    logic [IDX_W-1:0] tree_right  [DEF_NODE_COUNT];
    logic [SYM_W-1:0] tree_symbol [DEF_NODE_COUNT];
    logic [IDX_W-1:0] walk_pos;
    logic             want_header;
    logic [3:0]       tail_bits;
    logic             err_latched;
    logic [IDX_W-1:0] root_idx;

    walk_result_t pending_results [$];
    int           errors;
    int           items_sent;
    int           src_max_gap;
    int           snk_max_stall;
    int           hold_request;
    int unsigned  cycle_count;

    huffman_tree_walk_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    function automatic walk_result_t make_result(logic [SYM_W-1:0] sym, logic has,
                                                 logic [1:0] st);
        walk_result_t r;
        r             = '0;
        r.symbol      = sym;
        r.has_symbol  = has;
        r.status      = st;
        return r;
    endfunction

    // Advances the predicted walk by one accepted transaction and queues the
    // results it should produce.
    function automatic void walk_item(logic op, logic [S_TDATA_W-1:0] d, logic fin);
        walk_result_t     run [$];
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] nxt;
        logic [7:0]       b;
        logic             failed;
        int               bits;
        b      = d[43:36];
        failed = 1'b0;
        if (op == OP_LOAD) begin
            idx              = d[8:0];
            tree_leaf[idx]   = d[9];
            tree_left[idx]   = d[18:10];
            tree_right[idx]  = d[27:19];
            tree_symbol[idx] = d[35:28];
            tree_loaded[idx] = 1'b1;
            return;
        end
        if (err_latched) begin
            if (!fin)
                return;
            run = {run, make_result('0, 1'b0, STAT_OK)};
        end else if (want_header) begin
            if (b >= 8'd1 && b <= 8'd8) begin
                tail_bits   = b[3:0];
                want_header = 1'b0;
                walk_pos    = root_idx;
                if (fin)
                    run = {run, make_result('0, 1'b0, STAT_OK)};
            end else begin
                run    = {run, make_result('0, 1'b0, STAT_BAD_HEADER)};
                failed = 1'b1;
            end
        end else begin
            bits = fin ? int'(tail_bits) : 8;
            for (int i = 0; i < bits && !failed; i++) begin
                if (!tree_loaded[walk_pos]) begin
                    failed = 1'b1;
                end else begin
                    nxt = b[i] ? tree_right[walk_pos] : tree_left[walk_pos];
                    if (!tree_loaded[nxt]) begin
                        failed = 1'b1;
                    end else begin
                        walk_pos = nxt;
                        if (tree_leaf[nxt]) begin
                            run      = {run, make_result(tree_symbol[nxt], 1'b1, STAT_OK)};
                            walk_pos = root_idx;
                        end
                    end
                end
            end
            if (failed)
                run = {run, make_result('0, 1'b0, STAT_UNLOADED)};
            else if (fin && run.size() == 0)
                run = {run, make_result('0, 1'b0, STAT_OK)};
        end
        if (fin) begin
            if (run.size() > 0)
                run[run.size()-1].end_of_file = 1'b1;
            want_header = 1'b1;
            err_latched = 1'b0;
            walk_pos    = root_idx;
        end else if (failed) begin
            err_latched = 1'b1;
        end
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        pending_results = {pending_results, run};
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [S_TDATA_W-1:0] node_word(logic [IDX_W-1:0] idx, logic leaf,
                                                       logic [IDX_W-1:0] left,
                                                       logic [IDX_W-1:0] right,
                                                       logic [SYM_W-1:0] sym);
        logic [S_TDATA_W-1:0] w;
        w        = S_TDATA_W'({$urandom, $urandom});
        w[8:0]   = idx;
        w[9]     = leaf;
        w[18:10] = left;
        w[27:19] = right;
        w[35:28] = sym;
        w[47:44] = '0;
        return w;
    endfunction

    function automatic logic [S_TDATA_W-1:0] byte_word(logic [7:0] b);
        logic [S_TDATA_W-1:0] w;
        w        = S_TDATA_W'({$urandom, $urandom});
        w[43:36] = b;
        w[47:44] = '0;
        return w;
    endfunction

    // Offers one transaction after a random gap. Valid stays high afterwards so
    // that a following transaction can go out back to back.
    task automatic send_item(input logic op, input logic [S_TDATA_W-1:0] d, input logic fin);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        s_tlast  <= fin;
        do @(posedge aclk); while (s_tready !== 1'b1);
        walk_item(op, d, fin);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        send_item(OP_BYTE, byte_word(b), fin);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the root register while the decoder is idle and reads it back.
    task automatic set_root(input logic [IDX_W-1:0] idx);
        wait_idle();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROOT_NODE, 2'b00};
        pwdata  <= {23'($urandom), idx};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        root_idx = idx;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        check_field("root_node readback", 32'(idx), 32'(prdata[IDX_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Builds a random full code tree on consecutive indices starting at first
    // and stepping by step, the root last, and loads its nodes in random order.
    task automatic load_code_tree(input int first, input int step, input int n_leaves,
                                  input bit dangle, input bit root_leaf, output int root);
        int               slot  [32];
        logic             leaf  [32];
        logic [IDX_W-1:0] left  [32];
        logic [IDX_W-1:0] right [32];
        int               order [32];
        int               pool  [$];
        int               cnt;
        int               a;
        int               ia;
        int               ib;
        int               j;
        int               tmp;
        for (int i = 0; i < n_leaves; i++) begin
            slot[i]  = first + step * i;
            leaf[i]  = 1'b1;
            left[i]  = IDX_W'($urandom);
            right[i] = IDX_W'($urandom);
            pool     = {pool, i};
        end
        cnt = n_leaves;
        while (pool.size() > 1) begin
            a  = $urandom_range(0, pool.size() - 1);
            ia = pool[a];
            pool.delete(a);
            a  = $urandom_range(0, pool.size() - 1);
            ib = pool[a];
            pool.delete(a);
            slot[cnt]  = first + step * cnt;
            leaf[cnt]  = 1'b0;
            left[cnt]  = IDX_W'(slot[ia]);
            right[cnt] = IDX_W'(slot[ib]);
            pool       = {pool, cnt};
            cnt++;
        end
        root = slot[cnt-1];
        if (root_leaf)
            leaf[cnt-1] = 1'b1;
        if (dangle) begin
            j = $urandom_range(n_leaves, cnt - 1);
            if ($urandom_range(0, 1))
                left[j] = IDX_W'($urandom_range(HOLE_LO, HOLE_HI));
            else
                right[j] = IDX_W'($urandom_range(HOLE_LO, HOLE_HI));
        end
        for (int i = 0; i < cnt; i++)
            order[i] = i;
        for (int i = cnt - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < cnt; i++) begin
            j = order[i];
            send_item(OP_LOAD, node_word(IDX_W'(slot[j]), leaf[j], left[j], right[j],
                                         SYM_W'($urandom)), 1'($urandom));
        end
    endtask

    // Random file: header (sometimes bad), then n_data bytes, the last one
    // final. Stray node loads are mixed in now and then.
    task automatic send_file(input int n_data);
        int         pick;
        int         idx;
        logic [7:0] hdr;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            hdr = 8'd0;
        else if (pick == 1)
            hdr = 8'($urandom_range(9, 255));
        else
            hdr = 8'($urandom_range(1, 8));
        send_byte(hdr, n_data == 0);
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                idx = $urandom_range(0, NODE_MAX - (HOLE_HI - HOLE_LO + 1));
                if (idx >= HOLE_LO)
                    idx += HOLE_HI - HOLE_LO + 1;
                send_item(OP_LOAD, node_word(IDX_W'(idx), 1'($urandom), IDX_W'($urandom),
                                             IDX_W'($urandom), SYM_W'($urandom)),
                          1'($urandom));
            end
            send_byte(8'($urandom), i == n_data - 1);
        end
    endtask

    task automatic test_short_codes();
        int root;
        src_max_gap   = 0;
        snk_max_stall = 0;
        // Two leaves under a root at index 0: every bit yields a symbol.
        load_code_tree(2, -1, 2, 1'b0, 1'b0, root);
        set_root(IDX_W'(root));
        send_byte(8'd8, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // Empty file: the header is also the final byte.
        send_byte(8'd5, 1'b1);
        send_byte(8'd1, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_bad_headers();
        src_max_gap   = 3;
        snk_max_stall = 3;
        send_byte(8'd0, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(8'd9, 1'b0);
        send_byte(8'd8, 1'b1);
        send_byte(8'd8, 1'b0);
        send_byte(8'h96, 1'b1);
    endtask

    task automatic test_unloaded_nodes();
        int root;
        src_max_gap   = 2;
        snk_max_stall = 5;
        load_code_tree(NODE_MAX - 2, 1, 2, 1'b1, 1'b0, root);
        set_root(IDX_W'(root));
        send_byte(8'd8, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hF0, 1'b1);
        // A root that was never loaded fails on the first bit.
        set_root(IDX_W'(HOLE_LO + 3));
        send_byte(8'd4, 1'b0);
        send_byte(8'h0F, 1'b1);
        send_byte(8'd2, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    task automatic test_leaf_root();
        int root;
        src_max_gap   = 1;
        snk_max_stall = 1;
        load_code_tree(40, 1, 3, 1'b0, 1'b1, root);
        set_root(IDX_W'(root));
        send_byte(8'd3, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h96, 1'b1);
    endtask

    task automatic test_random_files();
        int start;
        int k;
        int n;
        int lo;
        int hi;
        int first;
        int step;
        int root;
        int mode;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 3);
            src_max_gap   = (mode == 1 || mode == 2) ? 8 : 0;
            snk_max_stall = (mode == 1 || mode == 3) ? 8 : 0;
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 6);
            n = 2 * k - 1;
            if ($urandom_range(0, 1)) begin
                lo = 0;
                hi = HOLE_LO - 1;
            end else begin
                lo = HOLE_HI + 1;
                hi = NODE_MAX;
            end
            if ($urandom_range(0, 1)) begin
                step  = 1;
                first = $urandom_range(lo, hi - n + 1);
            end else begin
                step  = -1;
                first = $urandom_range(lo + n - 1, hi);
            end
            load_code_tree(first, step, k, $urandom_range(0, 5) == 0,
                           $urandom_range(0, 7) == 0, root);
            if ($urandom_range(0, 9) == 0)
                root = $urandom_range(HOLE_LO, HOLE_HI);
            set_root(IDX_W'(root));
            repeat ($urandom_range(1, 3))
                send_file(($urandom_range(0, 5) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(0, 6));
        end
    endtask

    task automatic test_backpressure();
        int root;
        src_max_gap   = 0;
        snk_max_stall = 2;
        load_code_tree(HOLE_HI + 1, 1, 2, 1'b0, 1'b0, root);
        set_root(IDX_W'(root));
        // The receiver holds off after its next transaction while bytes keep coming.
        hold_request = 400;
        send_byte(8'd8, 1'b0);
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom), i == 23);
    endtask

    // Result side ready: a random stall before each transaction, or a long
    // hold when one is requested.
    initial begin
        int stall;
        forever begin
            stall = (hold_request > 0) ? hold_request : $urandom_range(0, snk_max_stall);
            hold_request = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 || aresetn !== 1'b1);
        end
    end

    always @(posedge aclk) begin : check_results
        walk_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual symbol %0h user %0h last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("symbol", 32'(want.symbol), 32'(m_tdata));
                check_field("has_symbol", 32'(want.has_symbol), 32'(m_tuser[0]));
                check_field("end_of_file", 32'(want.end_of_file), 32'(m_tuser[1]));
                check_field("status", 32'(want.status), 32'(m_tuser[3:2]));
                check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
            end
        end
    end

    initial begin
        walk_pos      = '0;
        want_header   = 1'b1;
        tail_bits     = BYTE_BITS;
        err_latched   = 1'b0;
        root_idx      = '0;
        errors        = 0;
        items_sent    = 0;
        src_max_gap   = 0;
        snk_max_stall = 0;
        hold_request  = 0;
        cycle_count   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_codes();
        test_bad_headers();
        test_unloaded_nodes();
        test_leaf_root();
        test_random_files();
        test_backpressure();
        wait_idle();

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* huffman_tree_walk_decoder_top.f */
hw/rtl/htwd_pkg.sv
hw/rtl/htwd_node_mem.sv
hw/rtl/htwd_apb_regs.sv
hw/rtl/htwd_walker.sv
hw/rtl/huffman_tree_walk_decoder_top.sv
sim/tb_top.sv
